// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the queue RTL.
// Every macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sgtq_pkg.sv -----
// Package for the grouped SPI transfer queue: default depth, operation and status codes.
// It depends on nothing else.
package sgtq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 128;

  typedef enum logic [1:0] {
    OpEnqueue = 2'd0,
    OpShift   = 2'd1,
    OpRead    = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusEmpty    = 2'd1,
    StatusOverflow = 2'd2,
    StatusRejected = 2'd3
  } status_e;

endpackage

// ----- hdl/sgtq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// It depends on nothing else; the read data holds while the read enable is low.
module sgtq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hdl/spi_grouped_transfer_queue_top.sv -----
// Grouped SPI transfer queue: send queue with group admission and a receive queue.
// An accepted input word has its result word in the output register in the next cycle.
// Throughput: one word per cycle while the output is not stalled; each word is one
// queue access done in one pass to the result register, reading at most one RAM.
// Reset (rst_ni low, asynchronous): queues empty, idle, select high, no result pending.
// Depends on sgtq_pkg, sgtq_ram and assert_macros.svh.
`include "assert_macros.svh"

module spi_grouped_transfer_queue_top
  import sgtq_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input channel.
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] data_byte_i,
  input  logic [6:0] group_length_i,
  input  logic [6:0] group_position_i,
  // Result channel.
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       send_valid_o,
  output logic [7:0] send_byte_o,
  output logic       select_n_o,
  output logic [7:0] read_byte_o,
  output logic [1:0] status_o,
  output logic [7:0] receive_count_o
);

  // Index width for the stores, count width for fills that may reach the depth itself,
  // and a sum width wide enough for a fill plus a 7-bit group length.
  localparam int unsigned AW   = $clog2(QueueDepth);
  localparam int unsigned CW   = $clog2(QueueDepth + 1);
  localparam int unsigned SumW = ((CW > 7) ? CW : 7) + 1;

  // Queue state. The state registers only change when a word is accepted, and a word is
  // only accepted when the result register is free, so they always describe the state
  // after the word whose result is on the output.
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] sent_q, sent_d;
  logic [CW-1:0] rx_fill_q, rx_fill_d;
  logic [AW-1:0] rpos_q, rpos_d;
  logic          running_q, running_d;
  logic          select_q, select_d;
  logic          drop_q, drop_d;

  // Result register.
  logic    out_valid_q, out_valid_d;
  logic    out_send_q, out_send_d;
  logic    out_read_q, out_read_d;
  status_e status_q, status_d;

  // The byte at the shifter is normally the registered send RAM output. When it was
  // written and emitted by the same word, the RAM returns stale data, so a copy of the
  // byte and its end mark is kept here and selected instead.
  logic       byp_q, byp_d;
  logic [7:0] byp_data_q, byp_data_d;
  logic       byp_mark_q, byp_mark_d;

  // RAM ports. The send RAM holds {end mark, byte}.
  logic          tx_we, tx_re;
  logic [8:0]    tx_rdata;
  logic          rx_we, rx_re;
  logic [7:0]    rx_rdata;

  logic          in_acc;
  logic          emit;
  logic          read_hit;
  logic          admit;
  logic          last;
  logic          cur_mark;
  logic [SumW-1:0] fill_sum;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // End of group: position + 1 reaches the group length.
  assign last     = ({1'b0, group_position_i} + 8'd1) >= {1'b0, group_length_i};
  assign fill_sum = SumW'(fill_q) + SumW'(group_length_i);
  assign cur_mark = byp_q ? byp_mark_q : tx_rdata[8];

  always_comb begin
    fill_d     = fill_q;
    sent_d     = sent_q;
    rx_fill_d  = rx_fill_q;
    rpos_d     = rpos_q;
    running_d  = running_q;
    select_d   = select_q;
    drop_d     = drop_q;
    byp_d      = byp_q;
    byp_data_d = byp_data_q;
    byp_mark_d = byp_mark_q;
    status_d   = StatusOk;
    tx_we      = 1'b0;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    emit       = 1'b0;
    read_hit   = 1'b0;
    admit      = 1'b0;

    if (in_acc) begin
      case (op_e'(operation_i))
        OpEnqueue: begin
          // The first byte of a group decides for the whole group.
          if (group_position_i == 7'd0) begin
            admit  = fill_sum < SumW'(QueueDepth);
            drop_d = ~admit;
          end else begin
            admit = ~drop_q;
          end
          if (fill_q >= CW'(QueueDepth)) begin
            admit = 1'b0;
          end
          if (!admit) begin
            status_d = StatusRejected;
          end else begin
            tx_we  = 1'b1;
            fill_d = fill_q + CW'(1);
            // A completed group starts an idle queue.
            if (last && !running_q && (sent_q < fill_d)) begin
              emit       = 1'b1;
              byp_d      = (sent_q == fill_q);
              byp_data_d = data_byte_i;
              byp_mark_d = last;
            end
          end
        end
        OpShift: begin
          if (running_q) begin
            // Received bytes beyond the depth are dropped.
            if (rx_fill_q < CW'(QueueDepth)) begin
              rx_we     = 1'b1;
              rx_fill_d = rx_fill_q + CW'(1);
            end
            // The byte closed its group: release the device unless a new byte goes out.
            if (cur_mark) begin
              select_d = 1'b1;
            end
            if (fill_q > sent_q) begin
              emit  = 1'b1;
              byp_d = 1'b0;
            end else begin
              running_d = 1'b0;
              sent_d    = '0;
              fill_d    = '0;
            end
          end
        end
        OpRead: begin
          if (rx_fill_q == '0) begin
            status_d = StatusEmpty;
          end else if (rx_fill_q < CW'(QueueDepth)) begin
            rx_re    = 1'b1;
            read_hit = 1'b1;
            rpos_d   = rpos_q + AW'(1);
            // The last held byte was popped: the receive queue starts over.
            if ((CW'(rpos_q) + CW'(1)) >= rx_fill_q) begin
              rpos_d    = '0;
              rx_fill_d = '0;
            end
          end else begin
            status_d = StatusOverflow;
          end
        end
        default: begin
        end
      endcase

      if (emit) begin
        sent_d    = sent_q + CW'(1);
        select_d  = 1'b0;
        running_d = 1'b1;
      end
    end
  end

  assign tx_re = emit;

  always_comb begin
    out_valid_d = out_valid_q;
    out_send_d  = out_send_q;
    out_read_d  = out_read_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      out_send_d  = emit;
      out_read_d  = read_hit;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      sent_q      <= '0;
      rx_fill_q   <= '0;
      rpos_q      <= '0;
      running_q   <= 1'b0;
      select_q    <= 1'b1;
      drop_q      <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_send_q  <= 1'b0;
      out_read_q  <= 1'b0;
      status_q    <= StatusOk;
    end else begin
      fill_q      <= fill_d;
      sent_q      <= sent_d;
      rx_fill_q   <= rx_fill_d;
      rpos_q      <= rpos_d;
      running_q   <= running_d;
      select_q    <= select_d;
      drop_q      <= drop_d;
      byp_q       <= byp_d;
      out_valid_q <= out_valid_d;
      out_send_q  <= out_send_d;
      out_read_q  <= out_read_d;
      if (in_acc) begin
        status_q <= status_d;
      end
    end
  end

  // The bypass copy is payload and needs no reset; its select bit is cleared above.
  always_ff @(posedge clk_i) begin
    byp_data_q <= byp_data_d;
    byp_mark_q <= byp_mark_d;
  end

  // Send store: written at the fill index, read at the send index when a byte goes out.
  sgtq_ram #(
    .Width(9),
    .Depth(QueueDepth)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i ({last, data_byte_i}),
    .re_i    (tx_re),
    .raddr_i (sent_q[AW-1:0]),
    .rdata_o (tx_rdata)
  );

  // Receive store: written at the receive fill index, read at the read index on a pop.
  sgtq_ram #(
    .Width(8),
    .Depth(QueueDepth)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_fill_q[AW-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (rx_re),
    .raddr_i (rpos_q),
    .rdata_o (rx_rdata)
  );

  // The RAM read data only moves together with a new result word, so it lines up with
  // the result register while the output is stalled.
  assign out_valid_o     = out_valid_q;
  assign send_valid_o    = out_send_q;
  assign send_byte_o     = out_send_q ? (byp_q ? byp_data_q : tx_rdata[7:0]) : 8'd0;
  assign select_n_o      = select_q;
  assign read_byte_o     = out_read_q ? rx_rdata : 8'd0;
  assign status_o        = status_q;
  assign receive_count_o = 8'(rx_fill_q);

  `ASSERT_IMPL(idle_sent_zero_a, !running_q, sent_q == '0, "send index not cleared while idle")
  `ASSERT_ALWAYS(sent_within_fill_a, sent_q <= fill_q, "send index ran past the fill")
  `ASSERT_IMPL(rpos_below_fill_a, rx_fill_q != '0, CW'(rpos_q) < rx_fill_q,
               "read index not below the receive fill")
  `ASSERT_NEXT(emit_selects_a, in_acc && emit, running_q && !select_q && out_send_q,
               "an emitted byte did not leave the queue running with select low")

endmodule
